// ===== rtl/core/slwk_pkg.sv =====
// ============================================================================
// slwk_pkg
// Shared widths, constants and polynomial coefficients for the Laguerre-
// Wendland C4 kernel datapath. All work values are Q30, signed in the accumulators.
// ============================================================================
package slwk_pkg;

    // Fixed-point formats
    localparam int WORK_FRAC = 30;   // fraction bits of the internal datapath
    localparam int OUT_FRAC  = 16;   // fraction bits of weight and gradient
    localparam int DIST_W    = 18;   // distance port width
    localparam int RES_W     = 32;   // result port width

    // Internal value widths (Q30)
    localparam int RW = 30;          // r, strictly below 1.0
    localparam int UW = 31;          // 1-r and its powers, up to exactly 1.0
    localparam int SW = 43;          // weight polynomial accumulator, |S| < 2^12
    localparam int GW = 46;          // gradient polynomial accumulator, |G| < 2^15
    localparam int MW = 46;          // product before normalization
    localparam int FW = 50;          // normalized weight and gradient
    localparam int KW = 34;          // normalization constant

    // Horner levels and pipeline depth
    localparam int S_LEVELS  = 6;
    localparam int G_LEVELS  = 5;
    localparam int PIPE_LAST = 16;   // index of the last datapath stage

    localparam logic [UW-1:0] U_ONE = UW'(1) << WORK_FRAC;

    // N/6 in Q30
    localparam logic [KW-1:0] K_3D = 34'd8018541104;
    localparam logic [KW-1:0] K_2D = 34'd1559837783;

    // Six times the two weight factors, and the matching derivative factor
    localparam int WEIGHT_POLY [0:6] = '{945, 486, -549, -324, 16, 36, 6};
    localparam int GRAD_POLY   [0:5] = '{11340, -324, -7920, -720, 1100, 220};

endpackage

// ===== rtl/core/slwk_qmul.sv =====
// ============================================================================
// slwk_qmul
// Two-stage Q30 multiplier: q = round(a*b / 2^30) + addend, rounding to
// nearest with ties away from zero. Operand a is split in two halves so that
// each partial product stays near 32x32; the partials are summed in stage two.
// ============================================================================
module slwk_qmul
    import slwk_pkg::*;
#(
    parameter int A_W = 43,
    parameter int B_W = 30,
    parameter int Q_W = 43
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [A_W-1:0] a,
    input  logic        [B_W-1:0] b,
    input  logic signed [Q_W-1:0] addend,
    output logic signed [Q_W-1:0] q
);

    localparam int LO_W  = A_W / 2;
    localparam int HI_W  = A_W - LO_W;
    localparam int PL_W  = LO_W + B_W;
    localparam int PH_W  = HI_W + B_W + 1;
    localparam int SUM_W = A_W + B_W + 2;

    // b is never negative, so the product sign is the sign of a
    localparam logic [SUM_W-1:0] RND_POS = SUM_W'(1) << (WORK_FRAC - 1);
    localparam logic [SUM_W-1:0] RND_NEG = RND_POS - SUM_W'(1);

    logic        [LO_W-1:0] a_lo;
    logic signed [HI_W-1:0] a_hi;
    logic        [PL_W-1:0] p_lo_next;
    logic        [PL_W-1:0] p_lo_reg;
    logic signed [PH_W-1:0] p_hi_next;
    logic signed [PH_W-1:0] p_hi_reg;
    logic                   neg_reg;
    logic signed [Q_W-1:0]  addend_reg;
    logic       [SUM_W-1:0] sum;
    logic signed [Q_W-1:0]  q_reg;

    // Stage 1: partial products
    assign a_lo      = a[LO_W-1:0];
    assign a_hi      = a[A_W-1:LO_W];
    assign p_lo_next = PL_W'(a_lo) * PL_W'(b);
    assign p_hi_next = PH_W'(a_hi) * PH_W'($signed({1'b0, b}));

    // Stage 2: recombine, round, add offset, drop fraction
    assign sum = (SUM_W'(p_hi_reg) << LO_W)
               + SUM_W'(p_lo_reg)
               + (SUM_W'(addend_reg) << WORK_FRAC)
               + (neg_reg ? RND_NEG : RND_POS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_lo_reg   <= p_lo_next;
            p_hi_reg   <= p_hi_next;
            neg_reg    <= a[A_W-1];
            addend_reg <= addend;
            q_reg      <= sum[WORK_FRAC +: Q_W];
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/core/sph_laguerre_wendland_kernel_top.sv =====
// ============================================================================
// sph_laguerre_wendland_kernel_top
// Laguerre-Wendland C4 smoothing kernel: weight and radial derivative of a
// normalized particle distance, Q16 in and out, with 2D/3D normalization.
// ============================================================================
//
//  channel   signals                          direction  payload
//  -------   -------------------------------  ---------  -------------------
//  cfg       cfg_write, cfg_data              in         three_dimensional
//  in        in_valid, in_ready, distance     in         r * 2^DIST_FRAC_BITS
//  out       out_valid, out_ready, weight,    out        Q16, saturated
//            gradient
//
//  One item per clock unless the skid slot is full. Between input accept
//  and out_valid lie an input register, eight two-stage Q30 multiply levels
//  (1-r powers and Horner chains side by side), a rounding output register.
//  A skid register behind the output lets one more item land while a result
//  waits; when it fills, the whole pipeline holds and in_ready drops.
//  Reset clears all valid bits and selects the 3D normalization.
//
module sph_laguerre_wendland_kernel_top
    import slwk_pkg::*;
#(
    parameter int DIST_FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic                     cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [DIST_W-1:0]        distance,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [RES_W-1:0]  weight,
    output logic signed [RES_W-1:0]  gradient
);

    localparam int R_SHIFT   = WORK_FRAC - DIST_FRAC_BITS;
    localparam int OUT_SHIFT = WORK_FRAC - OUT_FRAC;
    localparam int RND_W     = FW + 1 - OUT_SHIFT;
    localparam logic [FW:0] OUT_RND_POS = (FW+1)'(1) << (OUT_SHIFT - 1);
    localparam logic [FW:0] OUT_RND_NEG = OUT_RND_POS - (FW+1)'(1);

    // Q30 to Q16, magnitude rounded half away from zero, then saturated
    function automatic logic [RES_W-1:0] to_q16(input logic signed [FW-1:0] v);
        logic [FW:0]            biased;
        logic [RND_W-1:0]       rounded;
        logic [RND_W-RES_W:0]   top_bits;
        biased   = (FW+1)'(v) + (v[FW-1] ? OUT_RND_NEG : OUT_RND_POS);
        rounded  = biased[FW:OUT_SHIFT];
        top_bits = rounded[RND_W-1:RES_W-1];
        if (top_bits == '0 || top_bits == '1)
            to_q16 = rounded[RES_W-1:0];
        else if (rounded[RND_W-1])
            to_q16 = {1'b1, {(RES_W-1){1'b0}}};
        else
            to_q16 = {1'b0, {(RES_W-1){1'b1}}};
    endfunction

    // Control
    logic                  three_dimensional_reg;
    logic                  adv;
    logic [PIPE_LAST:0]    valid_reg;
    logic [PIPE_LAST:0]    beyond_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  incoming;

    // Input conversion
    logic                  beyond_in;
    logic [DIST_W+WORK_FRAC-1:0] r_wide;
    logic [RW-1:0]         r_in;
    logic [UW-1:0]         u_in;

    // Delay lines
    logic [RW-1:0]         r_stage_reg [0:2*(S_LEVELS-1)];
    logic [UW-1:0]         u_stage_reg [0:2];
    logic [UW-1:0]         u2_dly_reg  [0:1];
    logic [UW-1:0]         u6_dly_reg  [0:5];
    logic [UW-1:0]         ur_dly_reg  [0:1];
    logic signed [FW-1:0]  ugk_dly_reg;
    logic signed [FW-1:0]  grad_q30_reg;

    // Multiplier outputs
    logic [UW-1:0]         u2_q, u3_q, u5_q, u6_q, ur_q;
    logic signed [SW-1:0]  s_acc [0:S_LEVELS-1];
    logic signed [GW-1:0]  g_acc [0:G_LEVELS-1];
    logic signed [MW-1:0]  ug_q, ws_q;
    logic signed [FW-1:0]  ugk_q, wk_q;
    logic [KW-1:0]         k_sel;

    // Output side
    logic [RES_W-1:0]      w_res, g_res;
    logic signed [RES_W-1:0] weight_reg, gradient_reg;
    logic signed [RES_W-1:0] skid_weight_reg, skid_gradient_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            three_dimensional_reg <= 1'b1;
        else if (cfg_write)
            three_dimensional_reg <= cfg_data;
    end

    assign k_sel = three_dimensional_reg ? K_3D : K_2D;

    // Whole pipeline moves unless the skid slot is occupied
    assign adv      = !skid_valid_reg;
    assign in_ready = adv;

    // Distance to Q30 r and 1-r; r >= 1 is flagged and computed as r = 0
    assign beyond_in = (distance >> DIST_FRAC_BITS) != '0;
    assign r_wide    = {{WORK_FRAC{1'b0}}, distance} << R_SHIFT;
    assign r_in      = beyond_in ? '0 : r_wide[RW-1:0];
    assign u_in      = U_ONE - UW'(r_in);

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[PIPE_LAST-1:0], in_valid};
    end

    // Payload delay lines
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            beyond_reg <= {beyond_reg[PIPE_LAST-1:0], beyond_in};
            r_stage_reg[0] <= r_in;
            for (int i = 1; i <= 2*(S_LEVELS-1); i++)
                r_stage_reg[i] <= r_stage_reg[i-1];
            u_stage_reg[0] <= u_in;
            for (int i = 1; i <= 2; i++)
                u_stage_reg[i] <= u_stage_reg[i-1];
            u2_dly_reg[0] <= u2_q;
            u2_dly_reg[1] <= u2_dly_reg[0];
            u6_dly_reg[0] <= u6_q;
            for (int i = 1; i <= 5; i++)
                u6_dly_reg[i] <= u6_dly_reg[i-1];
            ur_dly_reg[0] <= ur_q;
            ur_dly_reg[1] <= ur_dly_reg[0];
            ugk_dly_reg   <= ugk_q;
            grad_q30_reg  <= -ugk_dly_reg;
        end
    end

    // Powers of 1-r: U2 (stage 2), U3 (4), U5 and U6 (6), U5*r (8)
    slwk_qmul #(.A_W(UW+1), .B_W(UW), .Q_W(UW)) u_mul_u2 (
        .clk    (clk),
        .en     (adv),
        .a      ({1'b0, u_stage_reg[0]}),
        .b      (u_stage_reg[0]),
        .addend ('0),
        .q      (u2_q)
    );

    slwk_qmul #(.A_W(UW+1), .B_W(UW), .Q_W(UW)) u_mul_u3 (
        .clk    (clk),
        .en     (adv),
        .a      ({1'b0, u2_q}),
        .b      (u_stage_reg[2]),
        .addend ('0),
        .q      (u3_q)
    );

    slwk_qmul #(.A_W(UW+1), .B_W(UW), .Q_W(UW)) u_mul_u5 (
        .clk    (clk),
        .en     (adv),
        .a      ({1'b0, u3_q}),
        .b      (u2_dly_reg[1]),
        .addend ('0),
        .q      (u5_q)
    );

    slwk_qmul #(.A_W(UW+1), .B_W(UW), .Q_W(UW)) u_mul_u6 (
        .clk    (clk),
        .en     (adv),
        .a      ({1'b0, u3_q}),
        .b      (u3_q),
        .addend ('0),
        .q      (u6_q)
    );

    slwk_qmul #(.A_W(UW+1), .B_W(RW), .Q_W(UW)) u_mul_ur (
        .clk    (clk),
        .en     (adv),
        .a      ({1'b0, u5_q}),
        .b      (r_stage_reg[6]),
        .addend ('0),
        .q      (ur_q)
    );

    // Horner chain for the weight polynomial, one level per two stages
    for (genvar k = 0; k < S_LEVELS; k++)
    begin : g_s_level
        logic signed [SW-1:0] s_in;
        if (k == 0)
        begin : g_first
            assign s_in = SW'(WEIGHT_POLY[0]) <<< WORK_FRAC;
        end
        else
        begin : g_next
            assign s_in = s_acc[k-1];
        end
        slwk_qmul #(.A_W(SW), .B_W(RW), .Q_W(SW)) u_mul (
            .clk    (clk),
            .en     (adv),
            .a      (s_in),
            .b      (r_stage_reg[2*k]),
            .addend (SW'(WEIGHT_POLY[k+1]) <<< WORK_FRAC),
            .q      (s_acc[k])
        );
    end

    // Horner chain for the derivative polynomial
    for (genvar k = 0; k < G_LEVELS; k++)
    begin : g_g_level
        logic signed [GW-1:0] g_in;
        if (k == 0)
        begin : g_first
            assign g_in = GW'(GRAD_POLY[0]) <<< WORK_FRAC;
        end
        else
        begin : g_next
            assign g_in = g_acc[k-1];
        end
        slwk_qmul #(.A_W(GW), .B_W(RW), .Q_W(GW)) u_mul (
            .clk    (clk),
            .en     (adv),
            .a      (g_in),
            .b      (r_stage_reg[2*k]),
            .addend (GW'(GRAD_POLY[k+1]) <<< WORK_FRAC),
            .q      (g_acc[k])
        );
    end

    // Gradient: G * U5*r (stage 12), then * K (stage 14)
    slwk_qmul #(.A_W(GW), .B_W(UW), .Q_W(MW)) u_mul_ug (
        .clk    (clk),
        .en     (adv),
        .a      (g_acc[G_LEVELS-1]),
        .b      (ur_dly_reg[1]),
        .addend ('0),
        .q      (ug_q)
    );

    slwk_qmul #(.A_W(MW), .B_W(KW), .Q_W(FW)) u_mul_ugk (
        .clk    (clk),
        .en     (adv),
        .a      (ug_q),
        .b      (k_sel),
        .addend ('0),
        .q      (ugk_q)
    );

    // Weight: S * U6 (stage 14), then * K (stage 16)
    slwk_qmul #(.A_W(SW), .B_W(UW), .Q_W(MW)) u_mul_ws (
        .clk    (clk),
        .en     (adv),
        .a      (s_acc[S_LEVELS-1]),
        .b      (u6_dly_reg[5]),
        .addend ('0),
        .q      (ws_q)
    );

    slwk_qmul #(.A_W(MW), .B_W(KW), .Q_W(FW)) u_mul_wk (
        .clk    (clk),
        .en     (adv),
        .a      (ws_q),
        .b      (k_sel),
        .addend ('0),
        .q      (wk_q)
    );

    // Final rounding; r >= 1 gives zero
    assign w_res    = beyond_reg[PIPE_LAST] ? '0 : to_q16(wk_q);
    assign g_res    = beyond_reg[PIPE_LAST] ? '0 : to_q16(grad_q30_reg);
    assign incoming = adv && valid_reg[PIPE_LAST];

    // Output register plus skid slot: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ready)
        begin
            if (incoming)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= incoming;
        end
    end

    // Output register plus skid slot: payload
    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ready)
        begin
            if (incoming)
            begin
                skid_weight_reg   <= w_res;
                skid_gradient_reg <= g_res;
            end
        end
        else if (skid_valid_reg)
        begin
            weight_reg   <= skid_weight_reg;
            gradient_reg <= skid_gradient_reg;
        end
        else if (incoming)
        begin
            weight_reg   <= w_res;
            gradient_reg <= g_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign weight    = weight_reg;
    assign gradient  = gradient_reg;

endmodule

// ===== tb/sv/tb_sph_laguerre_wendland_kernel_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_sph_laguerre_wendland_kernel_top
// Streams normalized distances through the kernel block under both the 2D and
// 3D normalizations, with random gaps on the input side and random stalls on
// the output side. Every result is checked field by field against a
// fixed-point evaluation of the kernel weight and its radial derivative.
// ============================================================================
module tb_sph_laguerre_wendland_kernel_top
    import slwk_pkg::*;
();

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_LIMIT   = 1000;   // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 40;     // wait for stray results after the drain
    localparam int DIST_FRAC    = 16;
    localparam int Q30          = 30;

    // N/6 in Q30 for each normalization
    localparam longint NORM_3D = 64'd8018541104;
    localparam longint NORM_2D = 64'd1559837783;

    // Distances for the opening pass: zero, tiny, r = 1/2, just below and at
    // one, beyond one, the top of the field, and alternating bit patterns
    localparam logic [DIST_W-1:0] EDGE_CASES [18] = '{
        18'd0,      18'd1,      18'd2,      18'd255,
        18'd32768,  18'd49152,  18'd65534,  18'd65535,
        18'd65536,  18'd65537,  18'd131071, 18'd131072,
        18'd262143, 18'h15555,  18'h2AAAA,  18'h05555,
        18'h0AAAA,  18'h0FF00
    };

    typedef struct {
        logic [DIST_W-1:0]        dist_in;
        logic signed [RES_W-1:0]  w;
        logic signed [RES_W-1:0]  g;
    } kernel_pair_t;

    // Kernel evaluation and in-order result check
    class kernel_pair_checker;
        kernel_pair_t expected_pairs[$];
        int           mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report(input string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        function bit [63:0] abs64(input longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        // Q30 product, rounded half away from zero, magnitude capped
        function longint q30_mul(input longint a, input longint b);
            bit          flip;
            bit [127:0]  p;
            longint      m;
            flip = (a < 0) != (b < 0);
            p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
            p = (p + (128'd1 << (Q30 - 1))) >> Q30;
            if (p > 128'h7FFF_FFFF_FFFF_FFFF)
                p = 128'h7FFF_FFFF_FFFF_FFFF;
            m = longint'(p[63:0]);
            return flip ? -m : m;
        endfunction

        // Horner over r: weight polynomial (times six) or derivative factor
        function longint poly_q30(input bit grad, input longint r);
            longint acc;
            longint c;
            int     n;
            n   = grad ? 6 : 7;
            acc = (grad ? 64'sd11340 : 64'sd945) <<< Q30;
            for (int i = 1; i < n; i++)
            begin
                if (grad)
                    unique case (i)
                        1: c = -324;
                        2: c = -7920;
                        3: c = -720;
                        4: c = 1100;
                        default: c = 220;
                    endcase
                else
                    unique case (i)
                        1: c = 486;
                        2: c = -549;
                        3: c = -324;
                        4: c = 16;
                        5: c = 36;
                        default: c = 6;
                    endcase
                acc = q30_mul(acc, r) + (c <<< Q30);
            end
            return acc;
        endfunction

        // Q30 to Q16, rounded half away from zero, saturated to 32 bits
        function logic signed [RES_W-1:0] q30_to_q16(input longint v);
            bit [63:0] m;
            m = abs64(v);
            m = (m >> (Q30 - 16)) + ((m >> (Q30 - 17)) & 64'd1);
            if (v < 0)
            begin
                if (m > 64'h8000_0000)
                    m = 64'h8000_0000;
                m = -m;
            end
            else if (m > 64'h7FFF_FFFF)
                m = 64'h7FFF_FFFF;
            return m[RES_W-1:0];
        endfunction

        function void note_distance(input logic [DIST_W-1:0] d, input bit three_d);
            kernel_pair_t e;
            longint r, u, u2, u3, u5, u6, s, gp, k;
            e.dist_in = d;
            if ((d >> DIST_FRAC) != 0)
            begin
                e.w = '0;
                e.g = '0;
            end
            else
            begin
                r  = longint'(d) << (Q30 - DIST_FRAC);
                u  = (longint'(1) << Q30) - r;
                u2 = q30_mul(u, u);
                u3 = q30_mul(u2, u);
                u5 = q30_mul(u3, u2);
                u6 = q30_mul(u3, u3);
                s  = poly_q30(1'b0, r);
                gp = poly_q30(1'b1, r);
                k  = three_d ? NORM_3D : NORM_2D;
                e.w = q30_to_q16(q30_mul(q30_mul(u6, s), k));
                e.g = q30_to_q16(-q30_mul(q30_mul(q30_mul(u5, r), gp), k));
            end
            expected_pairs.push_back(e);
        endfunction

        task check_pair(input logic signed [RES_W-1:0] w,
                        input logic signed [RES_W-1:0] g);
            kernel_pair_t e;
            if (expected_pairs.size() == 0)
            begin
                report($sformatf("result %0d/%0d with nothing outstanding", w, g));
                return;
            end
            e = expected_pairs.pop_front();
            if (w !== e.w)
                report($sformatf("distance %0d: weight %0d, want %0d",
                                 e.dist_in, w, e.w));
            if (g !== e.g)
                report($sformatf("distance %0d: gradient %0d, want %0d",
                                 e.dist_in, g, e.g));
        endtask

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_write = 1'b0;
    logic               cfg_data  = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [DIST_W-1:0]  distance  = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [RES_W-1:0] weight;
    logic signed [RES_W-1:0] gradient;

    kernel_pair_checker pairs = new();
    bit                 mode_3d = 1'b1;   // normalization after reset
    bit                 no_gaps = 1'b0;
    int                 idle_cycles = 0;

    sph_laguerre_wendland_kernel_top #(
        .DIST_FRAC_BITS (DIST_FRAC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .distance  (distance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .weight    (weight),
        .gradient  (gradient)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return 0;
        else if (sel < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(12, 40);
    endfunction

    // Mostly in range, weighted toward both ends, some beyond one
    function automatic logic [DIST_W-1:0] pick_distance();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            return DIST_W'($urandom_range(0, 255));
        else if (sel < 16)
            return DIST_W'($urandom_range(65280, 65535));
        else if (sel < 85)
            return DIST_W'($urandom_range(0, 65535));
        else if (sel < 88)
            return DIST_W'($urandom_range(65536, 65539));
        else
            return DIST_W'($urandom_range(65536, 262143));
    endfunction

    task automatic send_distance(input logic [DIST_W-1:0] d);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        distance <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pairs.note_distance(d, mode_3d);
    endtask

    // Register writes only with the pipeline empty
    task automatic set_dimension(input bit three_d);
        in_valid <= 1'b0;
        while (pairs.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= three_d;
        @(posedge clk);
        cfg_write <= 1'b0;
        mode_3d = three_d;
    endtask

    task automatic run_edge_cases();
        for (int i = 0; i < 18; i++)
            send_distance(EDGE_CASES[i]);
    endtask

    task automatic run_random(input int count, input bit steady);
        no_gaps = steady;
        for (int i = 0; i < count; i++)
            send_distance(pick_distance());
        no_gaps = 1'b0;
    endtask

    // Output side: random stalls, results checked on acceptance
    initial
    begin
        int run_left;
        int stall_left;
        run_left   = 0;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                pairs.check_pair(weight, gradient);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
                out_ready <= 1'b1;
            end
            else
            begin
                run_left   = $urandom_range(1, 24);
                stall_left = no_gaps ? 0 : pick_gap();
                out_ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // Watchdog: nothing accepted for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus: reset default, then alternating normalizations
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_edge_cases();
        set_dimension(1'b0);
        run_edge_cases();
        run_random(200, 1'b0);
        set_dimension(1'b1);
        run_random(200, 1'b0);
        set_dimension(1'b0);
        run_random(80, 1'b1);
        run_random(70, 1'b0);
        set_dimension(1'b1);
        run_random(100, 1'b0);
        in_valid <= 1'b0;

        // Drain, then give stray results time to show up
        while (pairs.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pairs.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
